/* src/ipwm_pkg.sv */
// ----------------------------------------------------------------------------
// ipwm_pkg
// shared constants, register map and letter decode for the primer matcher
// ----------------------------------------------------------------------------
package ipwm_pkg;

  localparam int WINDOW_BITS_DEFAULT = 32;

  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int CFG_SMALL = 6;
  localparam int PAT_W     = 32;

  typedef logic [2:0] reg_index_t;

  localparam reg_index_t REG_PATTERN_A          = 3'd0;
  localparam reg_index_t REG_PATTERN_C          = 3'd1;
  localparam reg_index_t REG_PATTERN_G          = 3'd2;
  localparam reg_index_t REG_PATTERN_T          = 3'd3;
  localparam reg_index_t REG_PRIMER_LENGTH      = 3'd4;
  localparam reg_index_t REG_MISMATCH_REGION    = 3'd5;
  localparam reg_index_t REG_MISMATCHES_ALLOWED = 3'd6;

  localparam logic [CFG_SMALL-1:0] PRIMER_LENGTH_RESET = 6'd32;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_Z = 8'h5A;

  // per nucleotide (a, c, g, t): bit n set when letter 'A'+n covers it
  localparam logic [31:0] BASE_TABLE [4] = '{
    32'h00621089, 32'h01241086, 32'h0026044a, 32'h0158048a
  };

  typedef logic [3:0] nuc_t;

  function automatic nuc_t nuc_bits(logic [7:0] ch);
    logic [4:0] idx;
    nuc_t       bits;
    idx  = '0;
    bits = '0;
    if (ch inside {[CHAR_A:CHAR_Z]}) begin
      idx = 5'(ch - CHAR_A);
      for (int k = 0; k < 4; k++) begin
        bits[k] = BASE_TABLE[k][idx];
      end
    end
    return bits;
  endfunction

endpackage

/* src/ipwm_if.sv */
// ----------------------------------------------------------------------------
// ipwm channel interfaces
// template letter request channel and match result channel
// ----------------------------------------------------------------------------
interface ipwm_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] base_char;
  logic       restart;

  modport source (output valid, output base_char, output restart, input ready);
  modport sink (input valid, input base_char, input restart, output ready);
endinterface

interface ipwm_result_if;
  logic       valid;
  logic       ready;
  logic       match;
  logic       conserved_ok;
  logic [5:0] agree_count;

  modport source (output valid, output match, output conserved_ok, output agree_count,
                  input ready);
  modport sink (input valid, input match, input conserved_ok, input agree_count,
                output ready);
endinterface

/* src/iupac_primer_window_matcher.sv */
// ----------------------------------------------------------------------------
// iupac_primer_window_matcher
// streaming iupac primer match with a tolerated mismatch region
// ----------------------------------------------------------------------------
// Takes one template letter per clock while results are taken and returns
// one result per letter. An accepted letter is decoded and shifted into the
// four nucleotide window registers; the result register is then loaded from
// the window AND pattern compare, the masks and the region popcount once the
// result stage can advance. That popcount over WINDOW_BITS positions is the
// path that sets the clock. The user must write configuration over the APB
// port only while no letter is in flight; the block itself does not
// enforce it.
// ----------------------------------------------------------------------------
module iupac_primer_window_matcher #(
  parameter int WINDOW_BITS = ipwm_pkg::WINDOW_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ipwm_pkg::ADDR_W-1:0] paddr,
  input  logic [ipwm_pkg::DATA_W-1:0] pwdata,
  output logic [ipwm_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  ipwm_item_if.sink                  item,
  ipwm_result_if.source              result
);
  import ipwm_pkg::*;

  localparam int W     = WINDOW_BITS;
  localparam int LEN_W = $clog2(W + 1);
  localparam int CW    = (LEN_W > CFG_SMALL) ? LEN_W : CFG_SMALL;
  localparam int EXT_W = (W > PAT_W) ? W : PAT_W;
  localparam logic [CW-1:0] W_VAL     = CW'(W);
  localparam logic [CW-1:0] COUNT_MAX = CW'(63);

  logic [PAT_W-1:0]     pattern_a, pattern_c, pattern_g, pattern_t;
  logic [CFG_SMALL-1:0] primer_length, mismatch_region, mismatches_allowed;

  logic [3:0][W-1:0] window;
  logic [3:0][W-1:0] window_next;
  logic              loaded;

  logic       cfg_write;
  reg_index_t cfg_idx;
  logic       accept;
  logic       advance;
  nuc_t       nuc;

  logic [CW-1:0] len, region, conserved, need, count;
  logic [W-1:0]  mask, cmask, agree;
  logic [3:0][W-1:0] pats;
  logic [EXT_W-1:0]  pa_ext, pc_ext, pg_ext, pt_ext;
  logic          conserved_ok_next;

  // config port
  assign pready    = 1'b1;
  assign cfg_idx   = reg_index_t'(paddr[ADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_a          <= '0;
      pattern_c          <= '0;
      pattern_g          <= '0;
      pattern_t          <= '0;
      primer_length      <= PRIMER_LENGTH_RESET;
      mismatch_region    <= '0;
      mismatches_allowed <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_PATTERN_A:          pattern_a          <= pwdata;
        REG_PATTERN_C:          pattern_c          <= pwdata;
        REG_PATTERN_G:          pattern_g          <= pwdata;
        REG_PATTERN_T:          pattern_t          <= pwdata;
        REG_PRIMER_LENGTH:      primer_length      <= pwdata[CFG_SMALL-1:0];
        REG_MISMATCH_REGION:    mismatch_region    <= pwdata[CFG_SMALL-1:0];
        REG_MISMATCHES_ALLOWED: mismatches_allowed <= pwdata[CFG_SMALL-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PATTERN_A:          prdata = pattern_a;
      REG_PATTERN_C:          prdata = pattern_c;
      REG_PATTERN_G:          prdata = pattern_g;
      REG_PATTERN_T:          prdata = pattern_t;
      REG_PRIMER_LENGTH:      prdata = DATA_W'(primer_length);
      REG_MISMATCH_REGION:    prdata = DATA_W'(mismatch_region);
      REG_MISMATCHES_ALLOWED: prdata = DATA_W'(mismatches_allowed);
      default:                prdata = '0;
    endcase
  end

  // length, region and masks
  always_comb begin
    len       = (CW'(primer_length) > W_VAL) ? W_VAL : CW'(primer_length);
    region    = (CW'(mismatch_region) > len) ? len : CW'(mismatch_region);
    conserved = len - region;
    need      = (region > CW'(mismatches_allowed)) ? region - CW'(mismatches_allowed) : '0;
    for (int i = 0; i < W; i++) begin
      mask[i]  = (CW'(i) < len);
      cmask[i] = (CW'(i) < conserved);
    end
  end

  // handshake and window shift
  assign advance    = !result.valid || result.ready;
  assign item.ready = !loaded || advance;
  assign accept     = item.valid && item.ready;
  assign nuc        = nuc_bits(item.base_char);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      window_next[k] = (((item.restart ? '0 : window[k]) << 1) | W'(nuc[k])) & mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      loaded <= 1'b0;
    end else begin
      if (accept) begin
        window <= window_next;
      end
      if (accept) begin
        loaded <= 1'b1;
      end else if (advance) begin
        loaded <= 1'b0;
      end
    end
  end

  // compare and count
  assign pa_ext = EXT_W'(pattern_a);
  assign pc_ext = EXT_W'(pattern_c);
  assign pg_ext = EXT_W'(pattern_g);
  assign pt_ext = EXT_W'(pattern_t);
  assign pats   = {pt_ext[W-1:0], pg_ext[W-1:0], pc_ext[W-1:0], pa_ext[W-1:0]};

  always_comb begin
    agree = '0;
    for (int k = 0; k < 4; k++) begin
      agree = agree | (window[k] & pats[k]);
    end
    agree = agree & mask;
    count = '0;
    for (int i = 0; i < W; i++) begin
      count = count + CW'(agree[i] & !cmask[i]);
    end
    if (count > COUNT_MAX) begin
      count = COUNT_MAX;
    end
    conserved_ok_next = ((agree & cmask) == cmask);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= loaded;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && loaded) begin
      result.conserved_ok <= conserved_ok_next;
      result.match        <= conserved_ok_next && (count >= need);
      result.agree_count  <= count[5:0];
    end
  end

  // checks
  a_match_needs_conserved: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (!result.match || result.conserved_ok))
    else $error("match without conserved agreement");

  a_count_in_window: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (CW'(result.agree_count) <= W_VAL))
    else $error("agree count beyond window");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    accept |=> loaded)
    else $error("accepted letter not held in window stage");

  a_stall_holds_window: assert property (@(posedge clk) disable iff (rst)
    (loaded && !advance) |=> (loaded && $stable(window)))
    else $error("window changed while its result was stalled");

  a_not_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !item.ready |-> (loaded && result.valid))
    else $error("request refused with room in the pipeline");

endmodule

/* verif/iupac_primer_window_matcher_tb.sv */
// ----------------------------------------------------------------------------
// iupac_primer_window_matcher_tb
// self-checking bench for the streaming primer window matcher
// ----------------------------------------------------------------------------
// Streams template letters into the matcher and predicts match, conserved_ok
// and agree_count for every accepted request from its own copy of the four
// window registers and the register file. Each configuration phase loads a
// primer (or random pattern bits), a length, a mismatch region and a
// tolerance over APB, then sends mostly primer-shaped runs with a few
// mutations plus random letters and bytes. Both channels idle and stall at
// random; one phase holds the result side off for a long stretch.
// ----------------------------------------------------------------------------
package match_check_pkg;
  import ipwm_pkg::*;

  typedef struct packed {
    logic       match;
    logic       conserved_ok;
    logic [5:0] agree_count;
  } verdict_t;

  class match_scoreboard;
    logic [31:0] pattern [4];
    logic [31:0] window [4];
    logic [5:0]  primer_len;
    logic [5:0]  region_len;
    logic [5:0]  allowed;
    verdict_t    pending [$];
    int          faults;

    function new();
      for (int k = 0; k < 4; k++) begin
        pattern[k] = '0;
        window[k]  = '0;
      end
      primer_len = PRIMER_LENGTH_RESET;
      region_len = '0;
      allowed    = '0;
      faults     = 0;
    endfunction

    function void set_register(reg_index_t idx, logic [31:0] val);
      case (idx)
        REG_PATTERN_A:          pattern[0] = val;
        REG_PATTERN_C:          pattern[1] = val;
        REG_PATTERN_G:          pattern[2] = val;
        REG_PATTERN_T:          pattern[3] = val;
        REG_PRIMER_LENGTH:      primer_len = val[5:0];
        REG_MISMATCH_REGION:    region_len = val[5:0];
        REG_MISMATCHES_ALLOWED: allowed    = val[5:0];
        default: ;
      endcase
    endfunction

    function void note_letter(logic [7:0] ch, logic rs);
      int unsigned len;
      int unsigned region;
      int unsigned kept;
      int unsigned need;
      int unsigned hits;
      int          k;
      logic [63:0] wide;
      logic [31:0] mask;
      logic [31:0] keep_mask;
      logic [31:0] agree;
      logic        nb;
      verdict_t    v;
      len    = (primer_len > 6'd32) ? 32 : primer_len;
      region = (region_len > len) ? len : region_len;
      kept   = len - region;
      need   = (region > allowed) ? region - allowed : 0;
      wide      = (64'd1 << len) - 64'd1;
      mask      = wide[31:0];
      wide      = (64'd1 << kept) - 64'd1;
      keep_mask = wide[31:0];
      agree = '0;
      for (k = 0; k < 4; k++) begin
        nb = (ch >= CHAR_A && ch <= CHAR_Z) ? BASE_TABLE[k][5'(ch - CHAR_A)] : 1'b0;
        if (rs) begin
          window[k] = '0;
        end
        window[k] = {window[k][30:0], nb} & mask;
        agree     = agree | (window[k] & pattern[k]);
      end
      hits = (kept >= 32) ? 0 : $countones(agree >> kept);
      v.conserved_ok = ((agree & keep_mask) == keep_mask);
      v.match        = v.conserved_ok && (hits >= need);
      v.agree_count  = hits[5:0];
      pending.push_back(v);
    endfunction

    function void check_result(logic m, logic c, logic [5:0] n);
      verdict_t want;
      if (pending.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("unexpected result: match=%0b conserved_ok=%0b agree_count=%0d", m, c, n);
        end
        return;
      end
      want = pending.pop_front();
      if (m !== want.match || c !== want.conserved_ok || n !== want.agree_count) begin
        faults++;
        if (faults <= 10) begin
          $write("result mismatch: expected match=%0b conserved_ok=%0b agree_count=%0d, ",
                 want.match, want.conserved_ok, want.agree_count);
          $display("got match=%0b conserved_ok=%0b agree_count=%0d", m, c, n);
        end
      end
    endfunction
  endclass
endpackage

module iupac_primer_window_matcher_tb;
  import ipwm_pkg::*;
  import match_check_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int PHASES = 15;
  localparam int LETTERS_PER_PHASE = 90;
  localparam logic [7:0] NUC_CHAR [4] = '{8'h41, 8'h43, 8'h47, 8'h54};

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  ipwm_item_if   item_ch ();
  ipwm_result_if result_ch ();

  match_scoreboard sb;

  logic [31:0] pat_bits [4];
  logic [5:0]  cur_len;
  logic [5:0]  cur_region;
  bit          tx_quiet;
  bit          rx_quiet;
  int          rx_hold;
  int          cycles;

  iupac_primer_window_matcher i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item_ch),
    .result  (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // result side: check, then pick ready for the next edge
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else begin
        if (result_ch.valid && result_ch.ready) begin
          sb.check_result(result_ch.match, result_ch.conserved_ok, result_ch.agree_count);
        end
        if (rx_hold > 0) begin
          stall_left = rx_hold;
          rx_hold    = 0;
        end
        if (stall_left > 0) begin
          stall_left--;
          result_ch.ready <= 1'b0;
        end else if (rx_quiet) begin
          result_ch.ready <= 1'b1;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 70) begin
            result_ch.ready <= 1'b1;
          end else begin
            result_ch.ready <= 1'b0;
            stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 60);
          end
        end
      end
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    sb.set_register(idx, val);
  endtask

  task automatic write_patterns();
    write_reg(REG_PATTERN_A, pat_bits[0]);
    write_reg(REG_PATTERN_C, pat_bits[1]);
    write_reg(REG_PATTERN_G, pat_bits[2]);
    write_reg(REG_PATTERN_T, pat_bits[3]);
  endtask

  task automatic configure(input logic [5:0] len, input logic [5:0] region,
                           input logic [5:0] tol);
    write_reg(REG_PRIMER_LENGTH, 32'(len));
    write_reg(REG_MISMATCH_REGION, 32'(region));
    write_reg(REG_MISMATCHES_ALLOWED, 32'(tol));
    cur_len    = len;
    cur_region = region;
  endtask

  task automatic send_letter(input logic [7:0] ch, input logic rs);
    int gap;
    int r;
    item_ch.valid     <= 1'b1;
    item_ch.base_char <= ch;
    item_ch.restart   <= rs;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_letter(ch, rs);
    r = $urandom_range(0, 99);
    if (tx_quiet || r < 55) begin
      gap = 0;
    end else if (r < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(5, 40);
    end
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // no request in flight and all results back
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_primer(input bit random_bits);
    int          b;
    int          k;
    logic [4:0]  idx;
    for (k = 0; k < 4; k++) begin
      pat_bits[k] = random_bits ? $urandom : 32'd0;
    end
    if (!random_bits) begin
      for (b = 0; b < 32; b++) begin
        idx = 5'($urandom_range(0, 25));
        while ($urandom_range(0, 9) != 0 && BASE_TABLE[0][idx] == 1'b0 &&
               BASE_TABLE[1][idx] == 1'b0 && BASE_TABLE[2][idx] == 1'b0 &&
               BASE_TABLE[3][idx] == 1'b0) begin
          idx = 5'($urandom_range(0, 25));
        end
        for (k = 0; k < 4; k++) begin
          pat_bits[k][b] = BASE_TABLE[k][idx];
        end
      end
    end
    write_patterns();
  endtask

  // primer-shaped run, oldest position first, with a few mutations
  task automatic send_primer_run(output int sent);
    int unsigned span;
    int unsigned region;
    int unsigned kept;
    int unsigned b;
    int          p;
    int          k;
    logic [31:0] bad;
    logic [7:0]  ch;
    logic [4:0]  idx;
    bit          fresh;
    span   = (cur_len > 6'd32) ? 32 : cur_len;
    region = (cur_region > span) ? span : cur_region;
    kept   = span - region;
    fresh  = $urandom_range(0, 1);
    bad    = '0;
    repeat ($urandom_range(0, 3)) begin
      if (region > 0 && $urandom_range(0, 9) < 7) begin
        bad[$urandom_range(kept, span - 1)] = 1'b1;
      end else begin
        bad[$urandom_range(0, span - 1)] = 1'b1;
      end
    end
    for (b = span; b > 0; b--) begin
      p = b - 1;
      if (bad[p]) begin
        ch = 8'($urandom_range(0, 255));
      end else if (!(pat_bits[0][p] | pat_bits[1][p] | pat_bits[2][p] | pat_bits[3][p])) begin
        ch = CHAR_A + 8'($urandom_range(0, 25));
      end else begin
        do k = $urandom_range(0, 3); while (!pat_bits[k][p]);
        if ($urandom_range(0, 3) == 0) begin
          do idx = 5'($urandom_range(0, 25)); while (!BASE_TABLE[k][idx]);
          ch = CHAR_A + 8'(idx);
        end else begin
          ch = NUC_CHAR[k];
        end
      end
      send_letter(ch, fresh && (b == span));
    end
    sent = span;
  endtask

  task automatic send_noise(output int sent);
    int n;
    logic [7:0] ch;
    n = $urandom_range(1, 6);
    repeat (n) begin
      ch = ($urandom_range(0, 1) == 0) ? CHAR_A + 8'($urandom_range(0, 25))
                                        : 8'($urandom_range(0, 255));
      send_letter(ch, $urandom_range(0, 9) == 0);
    end
    sent = n;
  endtask

  initial begin
    int          phase;
    int          sent;
    int          got;
    logic [5:0]  len;
    logic [5:0]  region;
    logic [5:0]  tol;
    sb = new();
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    item_ch.valid     <= 1'b0;
    item_ch.base_char <= '0;
    item_ch.restart   <= 1'b0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    rx_hold  = 0;
    cur_len    = PRIMER_LENGTH_RESET;
    cur_region = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset register values
    send_letter(8'h41, 1'b1);
    send_letter(8'h00, 1'b0);
    send_letter(8'hFF, 1'b0);
    settle();

    // exact four-letter primer, then letters outside the table
    pat_bits[0] = 32'h8;
    pat_bits[1] = 32'h4;
    pat_bits[2] = 32'h2;
    pat_bits[3] = 32'h1;
    write_patterns();
    configure(6'd4, 6'd0, 6'd0);
    send_letter(8'h41, 1'b1);
    send_letter(8'h43, 1'b0);
    send_letter(8'h47, 1'b0);
    send_letter(8'h54, 1'b0);
    send_letter(8'h4E, 1'b0);
    send_letter(8'h58, 1'b0);
    send_letter(8'h40, 1'b0);
    send_letter(8'h5B, 1'b0);
    send_letter(8'h61, 1'b0);
    send_letter(8'h00, 1'b0);
    send_letter(8'hFF, 1'b0);
    send_letter(8'h5A, 1'b0);
    settle();

    // empty window
    configure(6'd0, 6'd0, 6'd0);
    send_letter(8'h41, 1'b0);
    settle();

    // length above the window, region above length, tolerance above region
    configure(6'd40, 6'd50, 6'd63);
    send_letter(8'h47, 1'b0);
    send_letter(8'h54, 1'b0);

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      case (phase)
        0: begin len = 6'd32; region = 6'd32; tol = 6'd0;  end
        1: begin len = 6'd1;  region = 6'd0;  tol = 6'd0;  end
        2: begin len = 6'd63; region = 6'd63; tol = 6'd63; end
        3: begin len = 6'd32; region = 6'd8;  tol = 6'd2;  end
        4: begin
          len    = 6'd0;
          region = 6'($urandom_range(0, 63));
          tol    = 6'($urandom_range(0, 63));
        end
        5: begin len = 6'd32; region = 6'd0; tol = 6'd0; end
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            len    = 6'($urandom_range(0, 63));
            region = 6'($urandom_range(0, 63));
            tol    = 6'($urandom_range(0, 63));
          end else begin
            len    = 6'($urandom_range(1, 32));
            region = 6'($urandom_range(0, len + 3));
            tol    = 6'($urandom_range(0, region + 1));
          end
        end
      endcase
      load_primer(phase % 5 == 4);
      configure(len, region, tol);
      // long result hold-off while letters keep coming
      if (phase == 6) begin
        tx_quiet = 1'b1;
        rx_hold  = 250;
      end
      if (phase == 7) begin
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
      end
      sent = 0;
      while (sent < LETTERS_PER_PHASE) begin
        if (cur_len != 6'd0 && $urandom_range(0, 9) < 7) begin
          send_primer_run(got);
        end else begin
          send_noise(got);
        end
        sent += got;
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (sb.faults == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
src/ipwm_pkg.sv
src/ipwm_if.sv
src/iupac_primer_window_matcher.sv
verif/iupac_primer_window_matcher_tb.sv
